/* sv/trial_division_factorizer_macros.svh */
// ============================================================================
// Trial division factorizer assertion macros
// Shared assertion forms for the factorizer RTL.
// ============================================================================
`ifndef TRIAL_DIVISION_FACTORIZER_MACROS_SVH
`define TRIAL_DIVISION_FACTORIZER_MACROS_SVH

// Checked on every clock edge outside of reset.
`define TDF_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Checked on every clock edge, reset included.
`define TDF_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

/* sv/tdf_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// Trial division factorizer package
// Types and constants shared by the factorizer modules.
// ============================================================================
package tdf_pkg;

   // The first trial divisor, the first odd one after it, and the odd stride.
   localparam int unsigned FIRST_DIVISOR = 2;
   localparam int unsigned FIRST_ODD     = 3;
   localparam int unsigned CAND_STEP     = 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_EMIT
   } seq_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef struct packed {
      logic valid;
      logic last;
   } res_ctl_type;

endpackage

/* sv/tdf_req_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// Factorizer request channel
// Carries the value to factorize with a valid/ready handshake.
// ============================================================================
interface tdf_req_if #(
   parameter int VALUE_WIDTH = 31
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

/* sv/tdf_rsp_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// Factorizer response channel
// Carries one prime factor and a last flag with a valid/ready handshake.
// ============================================================================
interface tdf_rsp_if #(
   parameter int VALUE_WIDTH = 31
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] factor;
   logic                   last;

   modport source (output valid, output factor, output last, input ready);
   modport sink   (input valid, input factor, input last, output ready);
endinterface

/* sv/tdf_divider.sv */
`timescale 1ns / 1ps
// ============================================================================
// Factorizer divider
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
// ============================================================================
module tdf_divider #(
   parameter int VALUE_WIDTH = 31,
   parameter int CAND_WIDTH  = 17
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [VALUE_WIDTH-1:0]     dividend,
   input  logic [CAND_WIDTH-1:0]      divisor,
   output tdf_pkg::div_stat_type      stat,
   output logic [VALUE_WIDTH-1:0]     quotient,
   output logic [CAND_WIDTH-1:0]      remainder
);

   localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [CAND_WIDTH-1:0]  part_ff, part_in;
   logic [CAND_WIDTH-1:0]  dsr_ff, dsr_in;

   logic [CAND_WIDTH:0]    trial;
   logic [CAND_WIDTH:0]    diff;
   logic                   fits;

   // The dividend register shifts out its top bit as quotient bits shift in.
   assign trial = {part_ff, quo_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      part_in = part_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         part_in = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[VALUE_WIDTH-2:0], fits};
         part_in = fits ? diff[CAND_WIDTH-1:0] : trial[CAND_WIDTH-1:0];
         cnt_in  = cnt_ff + CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff  <= quo_in;
      part_ff <= part_in;
      dsr_ff  <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = part_ff;

endmodule

/* sv/tdf_seq.sv */
`timescale 1ns / 1ps
// ============================================================================
// Factorizer sequencer
// Steps the trial divisor and drives the divider, one trial at a time.
// ============================================================================
`include "trial_division_factorizer_macros.svh"

module tdf_seq #(
   parameter int VALUE_WIDTH = 31,
   parameter int CAND_WIDTH  = 17
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [VALUE_WIDTH-1:0]     req_value,
   output tdf_pkg::res_ctl_type       res_ctl,
   output logic [VALUE_WIDTH-1:0]     res_factor,
   input  logic                       res_ready,
   output logic                       div_start,
   output logic [VALUE_WIDTH-1:0]     div_dividend,
   output logic [CAND_WIDTH-1:0]      div_divisor,
   input  tdf_pkg::div_stat_type      div_stat,
   input  logic [VALUE_WIDTH-1:0]     div_quotient,
   input  logic [CAND_WIDTH-1:0]      div_remainder
);

   tdf_pkg::seq_state_type state_ff, state_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [CAND_WIDTH-1:0]  cand_ff, cand_in;
   logic [VALUE_WIDTH-1:0] factor_ff, factor_in;
   logic                   last_ff, last_in;

   logic [VALUE_WIDTH-1:0] cand_ext;
   logic [CAND_WIDTH-1:0]  cand_next;
   logic                   cand_is_first;
   logic                   cand_fits;
   logic                   divides;
   logic                   quo_is_one;
   logic                   value_small;

   assign cand_ext      = VALUE_WIDTH'(cand_ff);
   assign cand_is_first = cand_ff == CAND_WIDTH'(tdf_pkg::FIRST_DIVISOR);
   assign cand_next     = cand_is_first ? CAND_WIDTH'(tdf_pkg::FIRST_ODD)
                                        : cand_ff + CAND_WIDTH'(tdf_pkg::CAND_STEP);
   // The trial goes on while the candidate does not exceed remaining / candidate.
   assign cand_fits     = cand_ext <= div_quotient;
   assign divides       = div_remainder == '0;
   assign quo_is_one    = div_quotient == VALUE_WIDTH'(1);
   assign value_small   = req_value < VALUE_WIDTH'(tdf_pkg::FIRST_DIVISOR);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tdf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = value_small ? tdf_pkg::ST_EMIT : tdf_pkg::ST_START;
            end
         end
         tdf_pkg::ST_START: begin
            state_in = tdf_pkg::ST_WAIT;
         end
         tdf_pkg::ST_WAIT: begin
            if (div_stat.done) begin
               state_in = (cand_fits && !divides) ? tdf_pkg::ST_START : tdf_pkg::ST_EMIT;
            end
         end
         tdf_pkg::ST_EMIT: begin
            if (res_ready) begin
               state_in = last_ff ? tdf_pkg::ST_IDLE : tdf_pkg::ST_START;
            end
         end
         default: begin
            state_in = tdf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rem_in    = rem_ff;
      cand_in   = cand_ff;
      factor_in = factor_ff;
      last_in   = last_ff;
      req_ready = 1'b0;
      div_start = 1'b0;
      res_ctl.valid = 1'b0;
      res_ctl.last  = last_ff;
      unique case (state_ff)
         tdf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rem_in    = req_value;
               cand_in   = CAND_WIDTH'(tdf_pkg::FIRST_DIVISOR);
               factor_in = '0;
               last_in   = value_small;
            end
         end
         tdf_pkg::ST_START: begin
            div_start = 1'b1;
         end
         tdf_pkg::ST_WAIT: begin
            if (div_stat.done) begin
               if (cand_fits) begin
                  if (divides) begin
                     rem_in    = div_quotient;
                     factor_in = cand_ext;
                     last_in   = quo_is_one;
                  end else begin
                     cand_in = cand_next;
                  end
               end else begin
                  // No divisor left below the square root: what remains is prime.
                  factor_in = rem_ff;
                  last_in   = 1'b1;
               end
            end
         end
         tdf_pkg::ST_EMIT: begin
            res_ctl.valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign res_factor   = factor_ff;
   assign div_dividend = rem_ff;
   assign div_divisor  = cand_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdf_pkg::ST_IDLE;
         rem_ff   <= '0;
         cand_ff  <= CAND_WIDTH'(tdf_pkg::FIRST_DIVISOR);
      end else begin
         state_ff <= state_in;
         rem_ff   <= rem_in;
         cand_ff  <= cand_in;
      end
      factor_ff <= factor_in;
      last_ff   <= last_in;
   end

   `TDF_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == tdf_pkg::ST_IDLE), "sequencer not idle after reset")
   `TDF_ASSERT(a_start_free, clock, reset, div_start |-> !div_stat.busy, "division started while the divider is busy")
   `TDF_ASSERT(a_done_wait, clock, reset, div_stat.done |-> (state_ff == tdf_pkg::ST_WAIT), "division finished outside the wait state")
   `TDF_ASSERT(a_cand_odd, clock, reset, (state_ff != tdf_pkg::ST_IDLE) |-> (cand_is_first || cand_ff[0]), "trial divisor is even and not the first")
   `TDF_ASSERT(a_accept_busy, clock, reset, (req_valid && req_ready) |=> !req_ready, "new request taken while one is in work")

endmodule

/* sv/trial_division_factorizer.sv */
`timescale 1ns / 1ps
// ============================================================================
// Trial division factorizer
// Emits the prime factors of each request value in ascending order.
// ============================================================================
//
//   Channel  Dir  Payload              Transfer
//   req_chan in   value                valid && ready
//   rsp_chan out  factor, last         valid && ready
//
// Each trial divisor takes one run of the bit-serial divider, and a prime
// near 2^31 needs some 23,000 trials.
// Values 0 and 1 give one response (factor 0, last set).
// One request is in work at a time; req_chan is ready only when it is done.
// The response register lets the sequencer finish a factor while the
// previous one waits; a stalled rsp_chan holds the sequencer after that.
// Reset is synchronous and leaves the block idle at once.
//
module trial_division_factorizer #(
   parameter int VALUE_WIDTH = 31
) (
   input  logic      clock,
   input  logic      reset,
   tdf_req_if.sink   req_chan,
   tdf_rsp_if.source rsp_chan
);

   localparam int CAND_WIDTH = (VALUE_WIDTH + 1) / 2 + 1;

   tdf_pkg::res_ctl_type   res_ctl;
   logic [VALUE_WIDTH-1:0] res_factor;
   logic                   res_ready;

   tdf_pkg::div_stat_type  div_stat;
   logic                   div_start;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic [CAND_WIDTH-1:0]  div_divisor;
   logic [VALUE_WIDTH-1:0] div_quotient;
   logic [CAND_WIDTH-1:0]  div_remainder;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_factor_ff, rsp_factor_in;
   logic                   rsp_last_ff, rsp_last_in;

   tdf_seq #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CAND_WIDTH  (CAND_WIDTH)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_value     (req_chan.value),
      .res_ctl       (res_ctl),
      .res_factor    (res_factor),
      .res_ready     (res_ready),
      .div_start     (div_start),
      .div_dividend  (div_dividend),
      .div_divisor   (div_divisor),
      .div_stat      (div_stat),
      .div_quotient  (div_quotient),
      .div_remainder (div_remainder)
   );

   tdf_divider #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CAND_WIDTH  (CAND_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .stat      (div_stat),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // The response register takes a new factor when empty or being drained.
   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_factor_in = rsp_factor_ff;
      rsp_last_in   = rsp_last_ff;
      if (res_ready) begin
         rsp_valid_in  = res_ctl.valid;
         rsp_factor_in = res_factor;
         rsp_last_in   = res_ctl.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_factor_ff <= rsp_factor_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.factor = rsp_factor_ff;
   assign rsp_chan.last   = rsp_last_ff;

endmodule
